// ===== design/lqe_pkg.sv =====
// ============================================================================
// Link quality estimator package
// Shared widths, constants, state encoding and control types for the link
// quality estimator and its submodules.
// ============================================================================
package lqe_pkg;

    // Neighbor table size; must be a power of two no larger than 256.
    localparam int NEIGHBOR_SLOTS = 256;
    localparam int SLOT_W         = $clog2(NEIGHBOR_SLOTS);

    // Field widths.
    localparam int SINR_W     = 13;
    localparam int CNT_W      = 16;
    localparam int RATIO_W    = 17;
    localparam int QUAL_W     = 7;
    localparam int CFG_IDX_W  = 1;

    // Datapath widths.
    localparam int DIV_W      = 17;
    localparam int PROD_W     = SINR_W + RATIO_W;
    localparam int SCALED_W   = 20;
    localparam int RATIO_FRAC = 16;
    localparam int QBITS_LOW  = 7;

    // Sequencer step counts.
    localparam int STEP_CNT_W = 5;
    localparam int DIV1_STEPS = RATIO_W;
    localparam int DIV2_STEPS = QBITS_LOW + 1;

    // SINR constants in 1/16 dB.
    localparam logic signed [SINR_W-1:0] SINR_FLOOR     = {1'b1, {(SINR_W-1){1'b0}}};
    localparam logic signed [SINR_W:0]   SINR_STEP_3DB  = 14'sd48;
    localparam logic signed [SINR_W-1:0] SINR_MIN_RESET = 13'sd0;
    localparam logic signed [SINR_W-1:0] SINR_MAX_RESET = 13'sd320;

    // Quality ceiling in percent.
    localparam logic [QUAL_W-1:0] QUAL_MAX = 7'd100;

    // Configuration register indexes.
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_SINR_MIN = 1'b0;
    localparam cfg_idx_t REG_SINR_MAX = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV1,
        ST_MUL,
        ST_SCALE,
        ST_DIV2,
        ST_FINISH
    } lqe_state_t;

    // Control of the shared compare and subtract unit.
    typedef struct packed {
        logic load;
        logic step;
        logic shift;
        logic bit_in;
    } div_ctrl_t;

endpackage

// ===== design/link_quality_estimator.sv =====
// ============================================================================
// Link quality estimator
// Turns one neighbor interval report into a 0..100 link quality, keeping the
// last SINR and receive ratio of each neighbor slot.
// ============================================================================
// Sequence: history lookup, a 17-step ratio division on the shared
// compare/subtract unit (skipped when no frames were counted), product,
// scaling and an 8-step quality division, then a wait for a free output.
// Flow: one report at a time; the next is taken once the last result is loaded.
// Reset: aresetn is synchronous, active low; bounds return to 0 and 320, and
// every slot's history reads as -256 dB and ratio 0 right after reset.
module link_quality_estimator
    import lqe_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // Configuration write port
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [SINR_W-1:0]        cfg_wr_data,
    // Report input
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_neighbor_slot,
    input  logic                     s_first_report,
    input  logic signed [SINR_W-1:0] s_sinr_avg,
    input  logic [CNT_W-1:0]         s_rx_frames,
    input  logic [CNT_W-1:0]         s_missed_frames,
    // Quality output
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [QUAL_W-1:0]        m_link_quality
);

    lqe_state_t state_reg, state_next;

    logic [STEP_CNT_W-1:0]     cnt_reg;
    logic signed [SINR_W-1:0]  sinr_min_reg, sinr_max_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic                      first_reg;
    logic signed [SINR_W-1:0]  avg_reg;
    logic [CNT_W-1:0]          rx_reg, missed_reg;
    logic signed [SINR_W-1:0]  sinr_reg;
    logic [RATIO_W-1:0]        ratio_reg;
    logic                      used_div_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [QBITS_LOW-1:0]      pbits_reg;
    logic                      zero_reg, full_reg;
    logic                      m_valid_reg;
    logic [QUAL_W-1:0]         m_quality_reg;

    logic                      in_xfer;
    logic                      out_free;
    logic                      out_load;
    logic                      mem_wr_en;
    div_ctrl_t                 div_ctrl;
    logic [DIV_W-1:0]          div_load_rem, div_load_div, div_quo;

    logic signed [SINR_W-1:0]  rd_sinr, last_sinr;
    logic [RATIO_W-1:0]        rd_ratio, last_ratio;
    logic signed [SINR_W:0]    sinr_dec;
    logic signed [SINR_W-1:0]  sinr_decayed;
    logic [CNT_W:0]            total;
    logic [RATIO_W-1:0]        ratio_eff;
    logic signed [SINR_W:0]    diff, dcfg;
    logic                      above_min;
    logic [PROD_W-1:0]         prod_next;
    logic [PROD_W+6:0]         scaled_full;
    logic [SCALED_W-1:0]       scaled;
    logic [QBITS_LOW:0]        quo8;
    logic [QUAL_W-1:0]         qual_div, qual_final;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sinr_min_reg <= SINR_MIN_RESET;
            sinr_max_reg <= SINR_MAX_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SINR_MIN: sinr_min_reg <= cfg_wr_data;
                REG_SINR_MAX: sinr_max_reg <= cfg_wr_data;
                default:      ;
            endcase
        end
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_LOAD;
            ST_LOAD:   state_next = (total == '0) ? ST_MUL : ST_DIV1;
            ST_DIV1:   if (cnt_reg == STEP_CNT_W'(DIV1_STEPS - 1)) state_next = ST_MUL;
            ST_MUL:    state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_DIV2;
            ST_DIV2:   if (cnt_reg == STEP_CNT_W'(DIV2_STEPS - 1)) state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_ready         = 1'b0;
        mem_wr_en       = 1'b0;
        out_load        = 1'b0;
        div_ctrl        = '0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_LOAD: div_ctrl.load = (total != '0);
            ST_DIV1: begin
                div_ctrl.step  = 1'b1;
                div_ctrl.shift = (cnt_reg != '0);
            end
            ST_MUL:   mem_wr_en = 1'b1;
            ST_SCALE: div_ctrl.load = 1'b1;
            ST_DIV2: begin
                div_ctrl.step   = 1'b1;
                div_ctrl.shift  = (cnt_reg != '0);
                div_ctrl.bit_in = pbits_reg[QBITS_LOW-1];
            end
            ST_FINISH: out_load = out_free;
            default: ;
        endcase
    end

    assign in_xfer  = s_valid & s_ready;
    assign out_free = ~m_valid_reg | m_ready;

    // History after an optional first-report clear.
    assign last_sinr  = first_reg ? SINR_FLOOR : rd_sinr;
    assign last_ratio = first_reg ? '0 : rd_ratio;

    // Decay by 3 dB, saturating at the floor code.
    always_comb begin
        sinr_dec     = {last_sinr[SINR_W-1], last_sinr} - SINR_STEP_3DB;
        sinr_decayed = (sinr_dec < $signed({SINR_FLOOR[SINR_W-1], SINR_FLOOR})) ?
                       SINR_FLOOR : sinr_dec[SINR_W-1:0];
    end

    assign total = {1'b0, rx_reg} + {1'b0, missed_reg};

    // Quality arithmetic operands.
    always_comb begin
        ratio_eff   = used_div_reg ? div_quo[RATIO_W-1:0] : ratio_reg;
        diff        = {sinr_reg[SINR_W-1], sinr_reg} - {sinr_min_reg[SINR_W-1], sinr_min_reg};
        dcfg        = {sinr_max_reg[SINR_W-1], sinr_max_reg}
                    - {sinr_min_reg[SINR_W-1], sinr_min_reg};
        above_min   = ~diff[SINR_W] & (diff != '0);
        prod_next   = PROD_W'(diff[SINR_W-1:0]) * PROD_W'(ratio_eff);
        scaled_full = (PROD_W+7)'(prod_reg) * (PROD_W+7)'(QUAL_MAX);
        scaled      = scaled_full[RATIO_FRAC +: SCALED_W];
    end

    // Divider operands: receive ratio first, then the quality quotient.
    assign div_load_rem = (state_reg == ST_LOAD) ? DIV_W'(rx_reg)
                                                 : DIV_W'(scaled[SCALED_W-1:QBITS_LOW]);
    assign div_load_div = (state_reg == ST_LOAD) ? DIV_W'(total)
                                                 : DIV_W'(dcfg[SINR_W-1:0]);

    // Final quality selection and clamp.
    always_comb begin
        quo8       = div_quo[QBITS_LOW:0];
        qual_div   = (quo8 > (QBITS_LOW+1)'(QUAL_MAX)) ? QUAL_MAX : quo8[QUAL_W-1:0];
        qual_final = zero_reg ? '0 : (full_reg ? QUAL_MAX : qual_div);
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (div_ctrl.load) begin
                cnt_reg <= '0;
            end else if (div_ctrl.step) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            slot_reg   <= s_neighbor_slot[SLOT_W-1:0];
            first_reg  <= s_first_report;
            avg_reg    <= s_sinr_avg;
            rx_reg     <= s_rx_frames;
            missed_reg <= s_missed_frames;
        end
        if (state_reg == ST_LOAD) begin
            used_div_reg <= (total != '0);
            if (total == '0) begin
                sinr_reg  <= sinr_decayed;
                ratio_reg <= last_ratio;
            end else begin
                sinr_reg  <= avg_reg;
                ratio_reg <= last_ratio;
            end
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= prod_next;
            zero_reg <= ~above_min | dcfg[SINR_W];
            full_reg <= above_min & (dcfg == '0);
        end
        if (state_reg == ST_SCALE) begin
            pbits_reg <= scaled[QBITS_LOW-1:0];
        end else if (state_reg == ST_DIV2 && cnt_reg != '0) begin
            pbits_reg <= {pbits_reg[QBITS_LOW-2:0], 1'b0};
        end
        if (out_load) begin
            m_quality_reg <= qual_final;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_link_quality = m_quality_reg;

    lqe_hist_mem u_hist_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (in_xfer),
        .rd_addr  (s_neighbor_slot[SLOT_W-1:0]),
        .wr_en    (mem_wr_en),
        .wr_addr  (slot_reg),
        .wr_sinr  (sinr_reg),
        .wr_ratio (ratio_eff),
        .rd_sinr  (rd_sinr),
        .rd_ratio (rd_ratio)
    );

    lqe_div_unit u_div_unit (
        .aclk     (aclk),
        .ctrl     (div_ctrl),
        .load_rem (div_load_rem),
        .load_div (div_load_div),
        .quo      (div_quo)
    );

`ifndef SYNTHESIS
    // A result is never above the ceiling.
    a_quality_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_link_quality <= QUAL_MAX))
        else $error("link quality above ceiling");

    // A new result appears only from the finishing step.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == ST_FINISH))
        else $error("result valid without a finished report");

    // An input transfer always starts the history lookup.
    a_accept_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_LOAD))
        else $error("accepted report did not start processing");

    // Division step counters stay within their pass length.
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DIV1) |-> (cnt_reg < STEP_CNT_W'(DIV1_STEPS))) and
        ((state_reg == ST_DIV2) |-> (cnt_reg < STEP_CNT_W'(DIV2_STEPS))))
        else $error("division step counter out of range");
`endif

endmodule

// ===== design/lqe_div_unit.sv =====
// ============================================================================
// Shared restoring divider step unit
// Holds a partial remainder, divisor and quotient. Each step optionally shifts
// one dividend bit into the remainder, then compares and subtracts once.
// ============================================================================
module lqe_div_unit
    import lqe_pkg::*;
(
    input  logic             aclk,
    input  div_ctrl_t        ctrl,
    input  logic [DIV_W-1:0] load_rem,
    input  logic [DIV_W-1:0] load_div,
    output logic [DIV_W-1:0] quo
);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] div_reg;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W:0]   shifted;
    logic [DIV_W+1:0] trial;
    logic             ge;

    // One compare and subtract on the optionally shifted remainder.
    always_comb begin
        shifted  = ctrl.shift ? {rem_reg, ctrl.bit_in} : {1'b0, rem_reg};
        trial    = {1'b0, shifted} - {2'b00, div_reg};
        ge       = ~trial[DIV_W+1];
        rem_next = ge ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], ge};
    end

    // Operand load or one iteration per cycle.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            rem_reg <= load_rem;
            div_reg <= load_div;
            quo_reg <= '0;
        end else if (ctrl.step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

// ===== design/lqe_hist_mem.sv =====
// ============================================================================
// Neighbor history memory
// Per-slot last SINR and last receive ratio with a registered read port.
// Valid bits make unwritten slots read as the reset history.
// ============================================================================
module lqe_hist_mem
    import lqe_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     rd_en,
    input  logic [SLOT_W-1:0]        rd_addr,
    input  logic                     wr_en,
    input  logic [SLOT_W-1:0]        wr_addr,
    input  logic signed [SINR_W-1:0] wr_sinr,
    input  logic [RATIO_W-1:0]       wr_ratio,
    output logic signed [SINR_W-1:0] rd_sinr,
    output logic [RATIO_W-1:0]       rd_ratio
);

    logic [SINR_W+RATIO_W-1:0] mem [NEIGHBOR_SLOTS];
    logic [NEIGHBOR_SLOTS-1:0] valid_reg;
    logic [SINR_W+RATIO_W-1:0] rd_data_reg;
    logic                      rd_valid_reg;

    // Storage array write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_sinr, wr_ratio};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits clear at reset and mark written slots.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // A slot never written reads as the reset history.
    assign rd_sinr  = rd_valid_reg ? rd_data_reg[SINR_W+RATIO_W-1:RATIO_W] : SINR_FLOOR;
    assign rd_ratio = rd_valid_reg ? rd_data_reg[RATIO_W-1:0] : '0;

endmodule

// ===== tb/lqe_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Link quality estimator checker
// Watches the configuration port and both channels of the link quality
// estimator, predicts the quality of every accepted report from its own copy
// of the bounds and the per-slot history, and compares each result transfer
// with the oldest prediction still waiting.
// ============================================================================
module lqe_checker
    import lqe_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [SINR_W-1:0]        cfg_wr_data,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [7:0]               s_neighbor_slot,
    input  logic                     s_first_report,
    input  logic signed [SINR_W-1:0] s_sinr_avg,
    input  logic [CNT_W-1:0]         s_rx_frames,
    input  logic [CNT_W-1:0]         s_missed_frames,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [QUAL_W-1:0]        m_link_quality,
    output int                       error_count,
    output int                       expected_left
);

    typedef logic signed [SINR_W-1:0] sinr_t;

    // Q1.16 unity and the percent scale.
    localparam longint RATIO_ONE = 65536;
    localparam longint PERCENT   = 100;

    // Shadow of the bounds and of the per-slot history.
    sinr_t              bound_min;
    sinr_t              bound_max;
    sinr_t              slot_sinr  [NEIGHBOR_SLOTS];
    logic [RATIO_W-1:0] slot_ratio [NEIGHBOR_SLOTS];

    // Qualities predicted for accepted reports, oldest first.
    logic [QUAL_W-1:0]  awaited_quality [$];
    int                 fails = 0;

    initial begin
        error_count   = 0;
        expected_left = 0;
    end

    // Computes the quality of one report and updates the slot history.
    function automatic logic [QUAL_W-1:0] next_quality(
        input logic [7:0]        slot,
        input logic              first,
        input sinr_t             avg,
        input logic [CNT_W-1:0]  rx,
        input logic [CNT_W-1:0]  missed
    );
        int     idx;
        int     sinr;
        int     lo_b;
        int     hi_b;
        longint total;
        longint ratio;
        longint q;

        idx  = slot % NEIGHBOR_SLOTS;
        lo_b = bound_min;
        hi_b = bound_max;

        // A first report starts the neighbor from an empty history.
        if (first) begin
            slot_sinr[idx]  = SINR_FLOOR;
            slot_ratio[idx] = '0;
        end

        // Without frames the SINR decays by 3 dB and the old ratio is kept.
        total = rx + missed;
        if (total == 0) begin
            sinr = slot_sinr[idx] - SINR_STEP_3DB;
            if (sinr < SINR_FLOOR) begin
                sinr = SINR_FLOOR;
            end
            ratio = slot_ratio[idx];
        end else begin
            sinr  = avg;
            ratio = (longint'(rx) * RATIO_ONE) / total;
        end

        // Linear in SINR between the bounds, scaled by the ratio.
        q = 0;
        if (sinr > lo_b) begin
            if (hi_b == lo_b) begin
                q = PERCENT;
            end else if (hi_b > lo_b) begin
                q = (PERCENT * longint'(sinr - lo_b) * ratio) /
                    (longint'(hi_b - lo_b) * RATIO_ONE);
                if (q > PERCENT) begin
                    q = PERCENT;
                end
            end
        end

        slot_sinr[idx]  = sinr[SINR_W-1:0];
        slot_ratio[idx] = ratio[RATIO_W-1:0];
        return q[QUAL_W-1:0];
    endfunction

    // Track writes, predict on input transfers, compare on result transfers.
    always @(posedge aclk) begin
        logic [QUAL_W-1:0] want;

        if (!aresetn) begin
            bound_min = SINR_MIN_RESET;
            bound_max = SINR_MAX_RESET;
            for (int i = 0; i < NEIGHBOR_SLOTS; i++) begin
                slot_sinr[i]  = SINR_FLOOR;
                slot_ratio[i] = '0;
            end
            awaited_quality.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SINR_MIN: bound_min = cfg_wr_data;
                    REG_SINR_MAX: bound_max = cfg_wr_data;
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (awaited_quality.size() == 0) begin
                    $error("link_quality: result transfer with none expected, actual %0d",
                           m_link_quality);
                    fails++;
                end else begin
                    want = awaited_quality.pop_front();
                    if (m_link_quality !== want) begin
                        $error("link_quality mismatch: expected %0d, actual %0d",
                               want, m_link_quality);
                        fails++;
                    end
                end
            end

            if (s_valid && s_ready) begin
                awaited_quality = {awaited_quality,
                                   next_quality(s_neighbor_slot, s_first_report,
                                                s_sinr_avg, s_rx_frames,
                                                s_missed_frames)};
            end
        end

        error_count   <= fails;
        expected_left <= awaited_quality.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Link quality estimator testbench
// Drives neighbor interval reports and bound settings into the estimator,
// with random idle bursts on both channels, while the checker predicts and
// compares every quality result. Gives the final verdict.
// ============================================================================
module testbench;
    import lqe_pkg::*;

    typedef logic signed [SINR_W-1:0] sinr_t;

    // Cycle limit of the whole run.
    localparam int CYCLE_LIMIT  = 400000;
    // Cycles left after the last result for any stray transfer to show.
    localparam int DRAIN_CYCLES = 40;
    localparam int BURST_ITEMS  = 125;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    cfg_idx_t                 cfg_index = REG_SINR_MIN;
    logic [SINR_W-1:0]        cfg_wr_data = '0;
    logic                     s_valid = 1'b0;
    wire                      s_ready;
    logic [7:0]               s_neighbor_slot = '0;
    logic                     s_first_report = 1'b0;
    sinr_t                    s_sinr_avg = '0;
    logic [CNT_W-1:0]         s_rx_frames = '0;
    logic [CNT_W-1:0]         s_missed_frames = '0;
    wire                      m_valid;
    logic                     m_ready = 1'b0;
    wire  [QUAL_W-1:0]        m_link_quality;
    int                       error_count;
    int                       expected_left;

    // Idle bursts on both channels are allowed while this is set.
    bit                       idle_on = 1'b1;
    int                       cur_min = SINR_MIN_RESET;
    int                       cur_max = SINR_MAX_RESET;
    int                       cycle_count = 0;

    link_quality_estimator i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_neighbor_slot (s_neighbor_slot),
        .s_first_report  (s_first_report),
        .s_sinr_avg      (s_sinr_avg),
        .s_rx_frames     (s_rx_frames),
        .s_missed_frames (s_missed_frames),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_link_quality  (m_link_quality)
    );

    lqe_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_neighbor_slot (s_neighbor_slot),
        .s_first_report  (s_first_report),
        .s_sinr_avg      (s_sinr_avg),
        .s_rx_frames     (s_rx_frames),
        .s_missed_frames (s_missed_frames),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_link_quality  (m_link_quality),
        .error_count     (error_count),
        .expected_left   (expected_left)
    );

    // Clock of 10 ns.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Run guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: ready runs broken by random stall bursts.
    initial begin
        int run;
        forever begin
            m_ready <= 1'b1;
            run = $urandom_range(1, 40);
            repeat (run) @(posedge aclk);
            if (idle_on) begin
                m_ready <= 1'b0;
                run = $urandom_range(1, 17);
                repeat (run) @(posedge aclk);
            end
        end
    end

    // Presents one report and holds it until its transfer.
    task automatic send_report(input logic [7:0] slot, input logic first, input sinr_t sinr,
                               input logic [CNT_W-1:0] rx, input logic [CNT_W-1:0] missed);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_neighbor_slot <= slot;
        s_first_report  <= first;
        s_sinr_avg      <= sinr;
        s_rx_frames     <= rx;
        s_missed_frames <= missed;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stops the sender and waits until every expected result has come.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_left != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Writes both bounds while the block is idle.
    task automatic set_bounds(input int lo_v, input int hi_v);
        logic [SINR_W-1:0] lo_bits;
        logic [SINR_W-1:0] hi_bits;
        lo_bits = lo_v[SINR_W-1:0];
        hi_bits = hi_v[SINR_W-1:0];
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_SINR_MIN;
        cfg_wr_data <= lo_bits;
        @(posedge aclk);
        cfg_index   <= REG_SINR_MAX;
        cfg_wr_data <= hi_bits;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_min = lo_v;
        cur_max = hi_v;
    endtask

    // One random report: mostly a few busy slots and SINR near the bounds.
    task automatic send_random();
        logic [7:0]       slot;
        logic             first;
        sinr_t            sinr;
        logic [CNT_W-1:0] rx;
        logic [CNT_W-1:0] missed;
        int               lo;
        int               hi;
        int               pick;

        if ($urandom_range(0, 9) < 7) begin
            slot = 8'($urandom_range(0, 7));
        end else begin
            slot = 8'($urandom_range(0, 255));
        end
        first = ($urandom_range(0, 9) == 0);

        lo = ((cur_min < cur_max) ? cur_min : cur_max) - 64;
        hi = ((cur_min < cur_max) ? cur_max : cur_min) + 64;
        if (lo < -4096) lo = -4096;
        if (hi > 4095) hi = 4095;
        if ($urandom_range(0, 9) < 6) begin
            sinr = SINR_W'(lo + int'($urandom_range(0, hi - lo)));
        end else begin
            sinr = SINR_W'($urandom);
        end

        // Frame counts: silent intervals, one-sided counts, small and full values.
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1: begin
                rx     = '0;
                missed = '0;
            end
            2: begin
                rx     = '0;
                missed = CNT_W'($urandom);
            end
            3: begin
                rx     = CNT_W'($urandom);
                missed = '0;
            end
            4, 5: begin
                rx     = CNT_W'($urandom_range(0, 20));
                missed = CNT_W'($urandom_range(0, 20));
            end
            6: begin
                rx     = '1;
                missed = CNT_W'($urandom);
            end
            default: begin
                rx     = CNT_W'($urandom);
                missed = CNT_W'($urandom);
            end
        endcase
        send_report(slot, first, sinr, rx, missed);
    endtask

    task automatic random_burst(input int count);
        repeat (count) send_random();
    endtask

    // Stimulus and verdict.
    initial begin
        int lo_v;
        int hi_v;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset bounds: clamping, decay to the floor, exact bounds, odd ratios.
        send_report(8'd0,   1'b1, 4095,  16'hFFFF, 16'h0000);
        send_report(8'd0,   1'b0, 0,     16'h0000, 16'h0000);
        send_report(8'd255, 1'b1, -4096, 16'h0000, 16'hFFFF);
        send_report(8'd255, 1'b0, 100,   16'h0000, 16'h0000);
        send_report(8'd7,   1'b1, 2000,  16'h0000, 16'h0000);
        send_report(8'd10,  1'b0, 160,   16'h0001, 16'h0001);
        send_report(8'd10,  1'b0, 0,     16'h0005, 16'h0003);
        send_report(8'd10,  1'b0, 1,     16'hFFFF, 16'hFFFF);
        send_report(8'd10,  1'b0, 320,   16'h0003, 16'h0000);
        send_report(8'd10,  1'b0, 319,   16'hFFFF, 16'h0001);
        send_report(8'd10,  1'b0, 50,    16'h0000, 16'h0000);
        send_report(8'd128, 1'b1, 300,   16'h0000, 16'h0000);
        send_report(8'd170, 1'b0, 2730,  16'hAAAA, 16'h5555);
        send_report(8'd85,  1'b0, -2731, 16'h5555, 16'hAAAA);
        random_burst(BURST_ITEMS);

        // Widest bounds.
        set_bounds(-4096, 4095);
        send_report(8'd3, 1'b0, 4095,  16'h0010, 16'h0000);
        send_report(8'd3, 1'b0, -4095, 16'h0010, 16'h0000);
        random_burst(BURST_ITEMS);

        // Equal bounds saturate any SINR above them; no idling here.
        idle_on = 1'b0;
        set_bounds(100, 100);
        send_report(8'd4, 1'b0, 101, 16'h0001, 16'h00FF);
        send_report(8'd4, 1'b0, 100, 16'h0001, 16'h0000);
        random_burst(BURST_ITEMS);
        idle_on = 1'b1;

        // Inverted bounds give zero.
        set_bounds(200, -100);
        send_report(8'd5, 1'b0, 300, 16'h0100, 16'h0000);
        random_burst(BURST_ITEMS);

        // Both bounds at the top and at the bottom of the range.
        set_bounds(4095, 4095);
        random_burst(BURST_ITEMS);
        set_bounds(-4096, -4096);
        send_report(8'd6, 1'b0, -4095, 16'h0001, 16'h0000);
        random_burst(BURST_ITEMS);

        // Random bounds, mostly narrow spans; the second and last phases run without idling.
        for (int phase = 0; phase < 4; phase++) begin
            lo_v = -4096 + int'($urandom_range(0, 8191));
            if ($urandom_range(0, 3) == 0) begin
                hi_v = lo_v + int'($urandom_range(0, 8191));
            end else begin
                hi_v = lo_v + int'($urandom_range(1, 400));
            end
            if (hi_v > 4095) hi_v = 4095;
            idle_on = (phase == 1 || phase == 3) ? 1'b0 : 1'b1;
            set_bounds(lo_v, hi_v);
            random_burst(BURST_ITEMS);
        end

        // Drain and give the verdict.
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_left != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_left == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/lqe_pkg.sv
design/lqe_div_unit.sv
design/lqe_hist_mem.sv
design/link_quality_estimator.sv
tb/lqe_checker.sv
tb/testbench.sv
